// ----- sv/asras_pkg.sv -----
// shared types and constants for the angle sensor register access sequencer
// no dependencies
package asras_pkg;

  typedef enum logic [2:0] {
    OP_PREAD  = 3'd0,
    OP_PWRITE = 3'd1,
    OP_XREAD  = 3'd2,
    OP_XWRITE = 3'd3,
    OP_ANGLE  = 3'd4,
    OP_RESP   = 3'd5
  } op_t;

  localparam int unsigned STEP_W = 5;
  localparam int unsigned IDX_W  = STEP_W - 1;
  localparam int unsigned REG_W  = 6;

  // sensor register map used by the extended access sequences
  localparam logic [REG_W-1:0] REG_XR_ADDR = 6'h0A;
  localparam logic [REG_W-1:0] REG_XR_CTRL = 6'h0C;
  localparam logic [REG_W-1:0] REG_XR_HIGH = 6'h0E;
  localparam logic [REG_W-1:0] REG_XR_LOW  = 6'h10;
  localparam logic [REG_W-1:0] REG_XW_ADDR = 6'h02;
  localparam logic [REG_W-1:0] REG_XW_HIGH = 6'h04;
  localparam logic [REG_W-1:0] REG_XW_LOW  = 6'h06;
  localparam logic [REG_W-1:0] REG_XW_CTRL = 6'h08;

  localparam logic [15:0] CTRL_START = 16'h8000;
  localparam logic [15:0] ANGLE_CMD  = 16'h2000;
  localparam int unsigned ANGLE_W    = 12;

  // primary operation indexes inside the extended sequences
  localparam logic [IDX_W-1:0] IDX_XR_POLL = 4'd2;
  localparam logic [IDX_W-1:0] IDX_XR_HIGH = 4'd3;
  localparam logic [IDX_W-1:0] IDX_XW_POLL = 4'd4;
  localparam logic [IDX_W-1:0] IDX_X_LAST  = 4'd4;

  typedef struct packed {
    logic        frame_valid;
    logic [15:0] frame_word;
    logic        done_res;
    logic [31:0] read_result;
    logic        rejected;
  } result_t;

endpackage

// ----- sv/asras_frame_enc.sv -----
// command frame encoder: maps request, step and latched operands to a 16-bit frame
// depends on asras_pkg
module asras_frame_enc (
  input  asras_pkg::op_t                  req,
  input  logic [asras_pkg::STEP_W-1:0]    step,
  input  logic [15:0]                     addr,
  input  logic [31:0]                     held,
  output logic [15:0]                     frame
);
  import asras_pkg::*;

  logic [STEP_W-1:0] f;
  logic [IDX_W-1:0]  idx;
  logic              half;
  logic              is_write;
  logic [REG_W-1:0]  reg_sel;
  logic [15:0]       data;

  assign f    = step - STEP_W'(1);
  assign idx  = f[STEP_W-1:1];
  assign half = f[0];

  always_comb begin
    is_write = 1'b1;
    reg_sel  = '0;
    data     = '0;
    unique case (req)
      OP_PWRITE: begin
        reg_sel = addr[REG_W-1:0];
        data    = held[15:0];
      end
      OP_XREAD: begin
        unique case (idx)
          4'd0: begin
            reg_sel = REG_XR_ADDR;
            data    = addr;
          end
          4'd1: begin
            reg_sel = REG_XR_CTRL;
            data    = CTRL_START;
          end
          IDX_XR_POLL: begin
            is_write = 1'b0;
            reg_sel  = REG_XR_CTRL;
          end
          IDX_XR_HIGH: begin
            is_write = 1'b0;
            reg_sel  = REG_XR_HIGH;
          end
          default: begin
            is_write = 1'b0;
            reg_sel  = REG_XR_LOW;
          end
        endcase
      end
      OP_XWRITE: begin
        unique case (idx)
          4'd0: begin
            reg_sel = REG_XW_ADDR;
            data    = addr;
          end
          4'd1: begin
            reg_sel = REG_XW_HIGH;
            data    = held[31:16];
          end
          4'd2: begin
            reg_sel = REG_XW_LOW;
            data    = held[15:0];
          end
          4'd3: begin
            reg_sel = REG_XW_CTRL;
            data    = CTRL_START;
          end
          default: begin
            is_write = 1'b0;
            reg_sel  = REG_XW_CTRL;
          end
        endcase
      end
      default: begin
        is_write = 1'b0;
        reg_sel  = addr[REG_W-1:0];
      end
    endcase
  end

  always_comb begin
    if (req == OP_ANGLE) begin
      frame = ANGLE_CMD;
    end else if (!is_write) begin
      frame = {2'b00, reg_sel, 8'h00};
    end else if (!half) begin
      frame = {2'b01, reg_sel, data[15:8]};
    end else begin
      frame = {2'b01, reg_sel + REG_W'(1), data[7:0]};
    end
  end

endmodule

// ----- sv/angle_sensor_register_access_sequencer.sv -----
// results are registered in the output register, or in the skid while output stalls
// one transaction per cycle unless the skid is full; state updates in a single pass
// a two-entry output buffer (output register plus skid) keeps input accepting while
// one result waits
// reset: sequencer returns to idle, all latched operands clear, output buffer empties
// depends on asras_pkg and asras_frame_enc
module angle_sensor_register_access_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [15:0] reg_address,
  input  logic [31:0] write_data,
  input  logic [15:0] response_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_valid,
  output logic [15:0] frame_word,
  output logic        done_res,
  output logic [31:0] read_result,
  output logic        rejected
);
  import asras_pkg::*;

  logic [STEP_W-1:0] step, step_next;
  op_t               req, req_next;
  logic [15:0]       addr, addr_next;
  logic [31:0]       held, held_next;
  logic [15:0]       high_word, high_word_next;

  logic [STEP_W-1:0] f;
  logic [IDX_W-1:0]  idx;
  logic              poll;
  logic              last_op;
  logic [15:0]       enc_frame;
  logic              emit_frame;
  result_t           res_base;
  result_t           res;

  result_t out_q, skid_q;
  logic    skid_full;
  logic    accept_in;

  assign accept_in = in_valid && in_ready;
  assign in_ready  = !skid_full;

  assign f   = step - STEP_W'(1);
  assign idx = f[STEP_W-1:1];

  assign poll = (req == OP_XREAD && idx == IDX_XR_POLL) ||
                (req == OP_XWRITE && idx == IDX_XW_POLL);
  assign last_op = (req == OP_PREAD || req == OP_PWRITE) ? 1'b1 : (idx >= IDX_X_LAST);

  always_comb begin
    step_next      = step;
    req_next       = req;
    addr_next      = addr;
    held_next      = held;
    high_word_next = high_word;
    emit_frame     = 1'b0;
    res_base       = '0;
    if (opcode <= OP_ANGLE) begin
      if (step != '0) begin
        res_base.rejected = 1'b1;
      end else begin
        req_next   = op_t'(opcode);
        addr_next  = reg_address;
        held_next  = write_data;
        step_next  = STEP_W'(1);
        emit_frame = 1'b1;
      end
    end else if (opcode != OP_RESP || step == '0) begin
      res_base.rejected = 1'b1;
    end else if (req == OP_ANGLE) begin
      step_next            = '0;
      res_base.done_res    = 1'b1;
      res_base.read_result = {20'h0, response_word[ANGLE_W-1:0]};
    end else if (!f[0]) begin
      step_next  = step + STEP_W'(1);
      emit_frame = 1'b1;
    end else if (poll && !response_word[0]) begin
      step_next  = {idx, 1'b1};
      emit_frame = 1'b1;
    end else if (last_op) begin
      step_next         = '0;
      res_base.done_res = 1'b1;
      if (req == OP_PREAD) begin
        res_base.read_result = {16'h0, response_word};
      end else if (req == OP_XREAD) begin
        res_base.read_result = {high_word, response_word};
      end
    end else begin
      if (req == OP_XREAD && idx == IDX_XR_HIGH) begin
        high_word_next = response_word;
      end
      step_next  = step + STEP_W'(1);
      emit_frame = 1'b1;
    end
  end

  always_comb begin
    res             = res_base;
    res.frame_valid = emit_frame;
    res.frame_word  = emit_frame ? enc_frame : 16'h0;
  end

  asras_frame_enc u_frame_enc (
    .req   (req_next),
    .step  (step_next),
    .addr  (addr_next),
    .held  (held_next),
    .frame (enc_frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      req       <= OP_PREAD;
      addr      <= '0;
      held      <= '0;
      high_word <= '0;
    end else if (accept_in) begin
      step      <= step_next;
      req       <= req_next;
      addr      <= addr_next;
      held      <= held_next;
      high_word <= high_word_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= skid_full || accept_in;
      skid_full <= 1'b0;
    end else if (accept_in) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_q <= skid_full ? skid_q : res;
    end else if (accept_in) begin
      skid_q <= res;
    end
  end

  assign frame_valid = out_q.frame_valid;
  assign frame_word  = out_q.frame_word;
  assign done_res    = out_q.done_res;
  assign read_result = out_q.read_result;
  assign rejected    = out_q.rejected;

  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid entry held without a pending output");

  a_start_step : assert property (@(posedge clk) disable iff (rst)
    (accept_in && step == '0 && opcode <= OP_ANGLE) |=> step == STEP_W'(1))
    else $error("request accepted while idle did not start the sequence");

  a_angle_single : assert property (@(posedge clk) disable iff (rst)
    (step != '0 && req == OP_ANGLE) |-> step == STEP_W'(1))
    else $error("angle read advanced beyond its single frame");

  a_result_kind : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({out_q.frame_valid, out_q.done_res, out_q.rejected}) <= 1)
    else $error("result carries more than one outcome");

endmodule
